@@ design/kst_pkg.sv @@
// ----------------------------------------------------------------------------
// kst_pkg
// Shared widths and the command and status bundles that pass between the
// controller and the datapath of the spanning tree block.
// ----------------------------------------------------------------------------
`default_nettype none

package kst_pkg;

	localparam int MAX_NODES = 16;
	localparam int NODE_BITS = $clog2(MAX_NODES);
	localparam int COST_BITS = 16;
	localparam int CNT_BITS  = $clog2(MAX_NODES + 1);
	localparam int ADDR_BITS = 2 * NODE_BITS;
	localparam int KEY_BITS  = COST_BITS + ADDR_BITS;

	typedef struct packed {
		logic load;       // request accepted on the input side
		logic run_init;   // start of a run: reset components and result state
		logic scan_clr;   // restart the edge scan
		logic scan_run;   // advance the edge scan
		logic unite;      // evaluate the selected edge
		logic finish;     // emit the closing result and empty the store
	} cmd_t;

	typedef struct packed {
		logic scan_done;
		logic best_found;
		logic roots_differ;
		logic pending;
		logic out_free;
		logic taken_full;
	} sts_t;

endpackage

`default_nettype wire

@@ design/kst_ctrl.sv @@
// ----------------------------------------------------------------------------
// kst_ctrl
// Sequencer: load edges, repeat scan and join until the tree is full or no
// edge is left, then close the run.
// ----------------------------------------------------------------------------
`default_nettype none

module kst_ctrl (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_fire,
	input  wire logic         in_last,
	output logic              in_ready,
	input  wire kst_pkg::sts_t sts,
	output kst_pkg::cmd_t     cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_JOIN,
		ST_FINAL
	} state_t;

	state_t state_q;
	logic   join_ok;

	assign in_ready = (state_q == ST_IDLE);
	// a taken edge may push out the held one, which needs a free output
	assign join_ok  = !(sts.roots_differ && sts.pending && !sts.out_free);

	always_comb begin
		cmd = '0;
		cmd.load = in_fire;
		case (state_q)
			ST_IDLE: begin
				if (in_fire && in_last) begin
					cmd.run_init = 1'b1;
					cmd.scan_clr = 1'b1;
				end
			end
			ST_SCAN: begin
				cmd.scan_run = 1'b1;
			end
			ST_JOIN: begin
				if (join_ok) begin
					cmd.unite    = 1'b1;
					cmd.scan_clr = !(sts.roots_differ && sts.taken_full);
				end
			end
			ST_FINAL: begin
				cmd.finish = sts.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_fire && in_last) state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (sts.scan_done) state_q <= sts.best_found ? ST_JOIN : ST_FINAL;
				end
				ST_JOIN: begin
					if (join_ok) begin
						state_q <= (sts.roots_differ && sts.taken_full) ? ST_FINAL : ST_SCAN;
					end
				end
				ST_FINAL: begin
					if (sts.out_free) state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

@@ design/kst_dpath.sv @@
// ----------------------------------------------------------------------------
// kst_dpath
// Cost store, minimum-key edge scan, component labels and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module kst_dpath (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire kst_pkg::cmd_t                  cmd,
	output kst_pkg::sts_t                       sts,
	input  wire logic                           cfg_we,
	input  wire logic [kst_pkg::CNT_BITS-1:0]   cfg_nodes,
	input  wire logic [kst_pkg::NODE_BITS-1:0]  node_a,
	input  wire logic [kst_pkg::NODE_BITS-1:0]  node_b,
	input  wire logic [kst_pkg::COST_BITS-1:0]  edge_cost,
	input  wire logic                           out_ready,
	output logic                                out_valid,
	output logic [kst_pkg::NODE_BITS-1:0]       tree_src,
	output logic [kst_pkg::NODE_BITS-1:0]       tree_dest,
	output logic [kst_pkg::COST_BITS-1:0]       tree_cost,
	output logic                                edge_valid,
	output logic                                last_result
);

	localparam int NB    = kst_pkg::NODE_BITS;
	localparam int CB    = kst_pkg::COST_BITS;
	localparam int AB    = kst_pkg::ADDR_BITS;
	localparam int KB    = kst_pkg::KEY_BITS;
	localparam int NC    = kst_pkg::CNT_BITS;
	localparam int DEPTH = 1 << AB;

	logic [NC-1:0]  node_count_q;
	logic [NC-1:0]  n_act;
	logic [CB-1:0]  cost_mem [DEPTH];
	logic [DEPTH-1:0] vld_q;

	logic [NB-1:0]  lo_in, hi_in;
	logic           in_ok;

	logic [AB:0]    cnt_q;
	logic           rd_en_s1;
	logic           rd_vld_s1;
	logic [CB-1:0]  rd_cost_s1;
	logic [AB-1:0]  rd_addr_s1;
	logic [KB-1:0]  cand_key;
	logic           cand_ok;

	logic [KB-1:0]  best_key_q, prev_key_q;
	logic           best_found_q, have_prev_q;
	logic [NB-1:0]  best_lo, best_hi;

	logic [NB-1:0]  comp_q [kst_pkg::MAX_NODES];
	logic [NB-1:0]  lab_lo, lab_hi;
	logic [NB-1:0]  taken_q;
	logic           pend_q;
	logic [KB-1:0]  pend_key_q;
	logic           out_free;

	assign n_act = (node_count_q > NC'(kst_pkg::MAX_NODES)) ?
		NC'(kst_pkg::MAX_NODES) : node_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= NC'(kst_pkg::MAX_NODES);
		end else if (cfg_we) begin
			node_count_q <= cfg_nodes;
		end
	end

	// store each edge once, lower node in the row part of the address
	assign lo_in = (node_a < node_b) ? node_a : node_b;
	assign hi_in = (node_a < node_b) ? node_b : node_a;
	assign in_ok = ({1'b0, node_a} < n_act) && ({1'b0, node_b} < n_act) && (node_a != node_b);

	always_ff @(posedge clk) begin
		if (cmd.load && in_ok) cost_mem[{lo_in, hi_in}] <= edge_cost;
		rd_cost_s1 <= cost_mem[cnt_q[AB-1:0]];
		rd_addr_s1 <= cnt_q[AB-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (cmd.finish) begin
			vld_q <= '0;
		end else if (cmd.load && in_ok) begin
			vld_q[{lo_in, hi_in}] <= 1'b1;
		end
	end

	// scan key orders by cost, then by row-major position
	assign cand_key = {rd_cost_s1, rd_addr_s1};
	assign cand_ok  = rd_en_s1 && rd_vld_s1 && (rd_cost_s1 != '0)
		&& (rd_addr_s1[AB-1:NB] < rd_addr_s1[NB-1:0])
		&& ({1'b0, rd_addr_s1[NB-1:0]} < n_act)
		&& (!have_prev_q || cand_key > prev_key_q)
		&& (!best_found_q || cand_key < best_key_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q        <= '0;
			rd_en_s1     <= 1'b0;
			rd_vld_s1    <= 1'b0;
			best_found_q <= 1'b0;
		end else if (cmd.scan_clr) begin
			cnt_q        <= '0;
			rd_en_s1     <= 1'b0;
			best_found_q <= 1'b0;
		end else if (cmd.scan_run) begin
			rd_en_s1  <= !cnt_q[AB];
			rd_vld_s1 <= vld_q[cnt_q[AB-1:0]];
			if (!cnt_q[AB]) cnt_q <= cnt_q + 1'b1;
			if (cand_ok) best_found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_run && cand_ok) best_key_q <= cand_key;
	end

	assign best_lo = best_key_q[AB-1:NB];
	assign best_hi = best_key_q[NB-1:0];
	assign lab_lo  = comp_q[best_lo];
	assign lab_hi  = comp_q[best_hi];

	// component labels: merging relabels the higher node's set
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < kst_pkg::MAX_NODES; k++) comp_q[k] <= NB'(k);
			taken_q     <= '0;
			pend_q      <= 1'b0;
			have_prev_q <= 1'b0;
		end else if (cmd.run_init) begin
			for (int k = 0; k < kst_pkg::MAX_NODES; k++) comp_q[k] <= NB'(k);
			taken_q     <= '0;
			pend_q      <= 1'b0;
			have_prev_q <= 1'b0;
		end else if (cmd.unite) begin
			have_prev_q <= 1'b1;
			if (lab_lo != lab_hi) begin
				for (int k = 0; k < kst_pkg::MAX_NODES; k++) begin
					if (comp_q[k] == lab_hi) comp_q[k] <= lab_lo;
				end
				taken_q <= taken_q + 1'b1;
				pend_q  <= 1'b1;
			end
		end else if (cmd.finish) begin
			pend_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.unite) begin
			prev_key_q <= best_key_q;
			if (lab_lo != lab_hi) pend_key_q <= best_key_q;
		end
	end

	// result register: hold the taken edge until the next one shows it is not last
	assign out_free = !out_valid || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.finish || (cmd.unite && lab_lo != lab_hi && pend_q)) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			tree_src    <= pend_q ? pend_key_q[AB-1:NB] : '0;
			tree_dest   <= pend_q ? pend_key_q[NB-1:0] : '0;
			tree_cost   <= pend_q ? pend_key_q[KB-1:AB] : '0;
			edge_valid  <= pend_q;
			last_result <= 1'b1;
		end else if (cmd.unite && lab_lo != lab_hi && pend_q) begin
			tree_src    <= pend_key_q[AB-1:NB];
			tree_dest   <= pend_key_q[NB-1:0];
			tree_cost   <= pend_key_q[KB-1:AB];
			edge_valid  <= 1'b1;
			last_result <= 1'b0;
		end
	end

	assign sts.scan_done    = cnt_q[AB] && !rd_en_s1;
	assign sts.best_found   = best_found_q;
	assign sts.roots_differ = (lab_lo != lab_hi);
	assign sts.pending      = pend_q;
	assign sts.out_free     = out_free;
	assign sts.taken_full   = ({2'b0, taken_q} + (NB+2)'(2)) >= (NB+2)'(n_act);

endmodule

`default_nettype wire

@@ design/kruskal_spanning_tree.sv @@
// ----------------------------------------------------------------------------
// kruskal_spanning_tree
// Minimum spanning tree over up to 16 nodes from a stream of weighted edges.
// ----------------------------------------------------------------------------
// Edges arrive on the s_axis channel, one per request, and are written into
// the cost store; cost zero removes an edge. The request with tlast set
// starts a run. The run scans all 256 store slots for the next edge in
// (cost, row, column) order, then checks the component labels; there is
// one scan per edge considered.
// Tree edges leave on m_axis in the order taken, the final one with tlast;
// a run that takes no edge sends one result with edge_valid clear.
// No input is taken while a run is in progress. A stalled receiver holds
// the result register and the run waits on it; nothing is dropped.
// The user must write node_count (cfg channel, always ready) only while idle;
// the block does not enforce it. Reset empties the store, sets node_count to
// 16 and leaves the block idle; the store is emptied again after every run.
// ----------------------------------------------------------------------------
`default_nettype none

module kruskal_spanning_tree (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [4:0]  cfg_data,        // node_count
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [23:0] s_axis_tdata,    // node_a, node_b, edge_cost
	input  wire logic        s_axis_tlast,    // last_edge
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [23:0]      m_axis_tdata,    // tree_src, tree_dest, tree_cost
	output logic             m_axis_tuser,    // edge_valid
	output logic             m_axis_tlast     // last_result
);

	kst_pkg::cmd_t cmd;
	kst_pkg::sts_t sts;
	logic          in_fire;
	logic [3:0]    tree_src, tree_dest;
	logic [15:0]   tree_cost;

	assign cfg_ready = 1'b1;
	assign in_fire   = s_axis_tvalid && s_axis_tready;

	kst_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_fire  (in_fire),
		.in_last  (s_axis_tlast),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	kst_dpath u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.cfg_we      (cfg_valid && cfg_ready),
		.cfg_nodes   (cfg_data),
		.node_a      (s_axis_tdata[3:0]),
		.node_b      (s_axis_tdata[7:4]),
		.edge_cost   (s_axis_tdata[23:8]),
		.out_ready   (m_axis_tready),
		.out_valid   (m_axis_tvalid),
		.tree_src    (tree_src),
		.tree_dest   (tree_dest),
		.tree_cost   (tree_cost),
		.edge_valid  (m_axis_tuser),
		.last_result (m_axis_tlast)
	);

	assign m_axis_tdata = {tree_cost, tree_dest, tree_src};

	a_empty_run: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == 24'd0 && m_axis_tlast)
		else $error("empty result carries data or is not last");

	a_edge_order: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[3:0] < m_axis_tdata[7:4])
		else $error("tree edge endpoints out of order");

	a_edge_cost: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[23:8] != 16'd0)
		else $error("tree edge with zero cost");

endmodule

`default_nettype wire
